@@ hdl/frame_escape_codec_defines.svh @@
// assertion macros for the frame escape codec
// used by files that check their own logic; no other dependencies
`ifndef FRAME_ESCAPE_CODEC_DEFINES_SVH
`define FRAME_ESCAPE_CODEC_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame escape codec: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define FEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame escape codec: next-cycle check failed");

`endif

@@ hdl/fec_pkg.sv @@
// shared constants and types of the frame escape codec
// no dependencies; used by fec_step, the top level and the testbench
package fec_pkg;

    // flag, lead and tail bytes of the framing
    localparam logic [7:0] FLAG_START = 8'h5b;
    localparam logic [7:0] FLAG_END   = 8'h5d;
    localparam logic [7:0] LEAD_A     = 8'h5a;
    localparam logic [7:0] LEAD_E     = 8'h5e;
    localparam logic [7:0] TAIL_ONE   = 8'h01;
    localparam logic [7:0] TAIL_TWO   = 8'h02;

    // direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // one input request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_first;
        logic       frame_last;
    } item_t;

    // one result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_done;
        logic       frame_bad;
    } result_t;

    // codec state carried between requests
    typedef struct packed {
        logic lead_held;
        logic lead_e;     // held lead is 0x5e, else 0x5a
        logic start_ok;
    } state_t;

endpackage

@@ hdl/fec_stream_if.sv @@
// valid/ready channel interfaces for the input bytes and the results
// depends on nothing; its field widths match those of fec_pkg
interface fec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_first;
    logic       frame_last;

    modport source (output valid, output in_byte, output frame_first,
                    output frame_last, input ready);
    modport sink (input valid, input in_byte, input frame_first,
                  input frame_last, output ready);
endinterface

interface fec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
    logic       frame_bad;

    modport source (output valid, output out_byte, output run_last,
                    output frame_done, output frame_bad, input ready);
    modport sink (input valid, input out_byte, input run_last,
                  input frame_done, input frame_bad, output ready);
endinterface

@@ hdl/fec_step.sv @@
// combinational conversion of one request into zero, one or two results
// depends on fec_pkg
module fec_step (
    input  logic             direction,
    input  fec_pkg::item_t   item,
    input  fec_pkg::state_t  state,
    output fec_pkg::state_t  state_next,
    output logic [1:0]       res_cnt,
    output fec_pkg::result_t res0,
    output fec_pkg::result_t res1
);

    logic [7:0] b;
    logic [7:0] lead_val;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       b_is_lead;
    logic       b_is_tail;
    logic       bad;

    assign b         = item.in_byte;
    assign lead_val  = state.lead_e ? fec_pkg::LEAD_E : fec_pkg::LEAD_A;
    assign b_is_lead = (b == fec_pkg::LEAD_A) || (b == fec_pkg::LEAD_E);
    assign b_is_tail = (b == fec_pkg::TAIL_ONE) || (b == fec_pkg::TAIL_TWO);

    // frame check, reported on the final result of the frame
    assign bad = !(item.frame_first ? (b == fec_pkg::FLAG_START) : state.start_ok)
                 || (b != fec_pkg::FLAG_END);

    // result bytes, lead tracking and start flag tracking
    always_comb
    begin
        byte0                = b;
        byte1                = b;
        res_cnt              = 2'd1;
        state_next.lead_held = 1'b0;
        state_next.lead_e    = 1'b0;

        // start flag tracking
        priority if (item.frame_last)
            state_next.start_ok = 1'b0;
        else if (item.frame_first)
            state_next.start_ok = (b == fec_pkg::FLAG_START);
        else
            state_next.start_ok = state.start_ok;

        priority if (item.frame_first)
        begin
            res_cnt = 2'd1;
        end
        else if (item.frame_last)
        begin
            if (direction == fec_pkg::DIR_DECODE && state.lead_held)
            begin
                byte0   = lead_val;
                res_cnt = 2'd2;
            end
        end
        else if (direction == fec_pkg::DIR_ENCODE)
        begin
            priority if (b == fec_pkg::FLAG_START)
            begin
                byte0   = fec_pkg::LEAD_A;
                byte1   = fec_pkg::TAIL_ONE;
                res_cnt = 2'd2;
            end
            else if (b == fec_pkg::LEAD_A)
            begin
                byte0   = fec_pkg::LEAD_A;
                byte1   = fec_pkg::TAIL_TWO;
                res_cnt = 2'd2;
            end
            else if (b == fec_pkg::FLAG_END)
            begin
                byte0   = fec_pkg::LEAD_E;
                byte1   = fec_pkg::TAIL_ONE;
                res_cnt = 2'd2;
            end
            else if (b == fec_pkg::LEAD_E)
            begin
                byte0   = fec_pkg::LEAD_E;
                byte1   = fec_pkg::TAIL_TWO;
                res_cnt = 2'd2;
            end
            else
            begin
                res_cnt = 2'd1;
            end
        end
        else if (state.lead_held && b_is_tail)
        begin
            // complete the escape pair
            if (state.lead_e)
                byte0 = (b == fec_pkg::TAIL_ONE) ? fec_pkg::FLAG_END : fec_pkg::LEAD_E;
            else
                byte0 = (b == fec_pkg::TAIL_ONE) ? fec_pkg::FLAG_START : fec_pkg::LEAD_A;
            res_cnt = 2'd1;
        end
        else if (state.lead_held)
        begin
            // unpaired lead goes out unchanged
            byte0 = lead_val;
            if (b_is_lead)
            begin
                res_cnt              = 2'd1;
                state_next.lead_held = 1'b1;
                state_next.lead_e    = (b == fec_pkg::LEAD_E);
            end
            else
            begin
                res_cnt = 2'd2;
            end
        end
        else if (b_is_lead)
        begin
            // hold the lead until its partner shows up
            res_cnt              = 2'd0;
            state_next.lead_held = 1'b1;
            state_next.lead_e    = (b == fec_pkg::LEAD_E);
        end
        else
        begin
            res_cnt = 2'd1;
        end
    end

    // flags go on the last result of the request
    always_comb
    begin
        res0.out_byte   = byte0;
        res0.run_last   = (res_cnt == 2'd1);
        res0.frame_done = (res_cnt == 2'd1) && item.frame_last;
        res0.frame_bad  = (res_cnt == 2'd1) && item.frame_last && bad;
        res1.out_byte   = byte1;
        res1.run_last   = 1'b1;
        res1.frame_done = item.frame_last;
        res1.frame_bad  = item.frame_last && bad;
    end

endmodule

@@ hdl/frame_escape_codec.sv @@
// top level of the frame escape codec: request register, conversion, result buffer
// depends on fec_pkg, fec_stream_if, fec_step and frame_escape_codec_defines.svh
//
// Usage:
//   rx carries the frame bytes with frame_first / frame_last marks; tx returns
//   the converted bytes, one per transfer, with run_last on the last byte that
//   a request produced and frame_done / frame_bad on the final byte of a frame.
//   cfg_wr_en / cfg_wr_data write the direction bit (0 encode, 1 decode); write
//   it only while no request is in flight.
// Path: a request is taken into the request register and, once the result buffer
//   has room, converted by fec_step; its results are registered in that buffer,
//   which drives tx valid and the tx bytes.
// Throughput: one request per cycle while tx is ready and each produces one result;
//   a request that expands to two bytes holds off the next one until the
//   one-byte-per-cycle tx channel has drained the two-entry result buffer down to
//   its last entry. A decode lead that is only held produces no result.
// Reset: rst_n (asynchronous, low) empties the request register and the result
//   buffer, clears the held lead and the start flag state and selects encode.
// Stall: while tx is not ready the result buffer holds; the request register
//   then fills and rx.ready drops until the buffer has room again.
`include "frame_escape_codec_defines.svh"

module frame_escape_codec (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    fec_in_if.sink         rx,
    fec_out_if.source      tx
);

    logic             dir_reg;
    logic             in_vld_reg;
    fec_pkg::item_t   item_reg;
    fec_pkg::state_t  state_reg;
    fec_pkg::state_t  state_next;
    logic [1:0]       res_cnt_reg;
    logic [1:0]       res_cnt_next;
    fec_pkg::result_t res0_reg;
    fec_pkg::result_t res0_next;
    fec_pkg::result_t res1_reg;
    fec_pkg::result_t res1_next;
    logic [1:0]       step_cnt;
    fec_pkg::result_t step_res0;
    fec_pkg::result_t step_res1;
    logic             tx_fire;
    logic             rx_fire;
    logic             room;
    logic             proc;

    // handshake control
    assign tx_fire  = tx.valid && tx.ready;
    assign rx_fire  = rx.valid && rx.ready;
    assign room     = (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && tx_fire);
    assign proc     = in_vld_reg && room;
    assign rx.ready = !in_vld_reg || proc;

    // direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= fec_pkg::DIR_ENCODE;
        else if (cfg_wr_en)
            dir_reg <= cfg_wr_data;
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (rx.ready)
            in_vld_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            item_reg.in_byte     <= rx.in_byte;
            item_reg.frame_first <= rx.frame_first;
            item_reg.frame_last  <= rx.frame_last;
        end
    end

    // conversion of the registered request
    fec_step u_step (
        .direction  (dir_reg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res_cnt    (step_cnt),
        .res0       (step_res0),
        .res1       (step_res1)
    );

    // codec state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (proc)
            state_reg <= state_next;
    end

    // result buffer next value
    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        res0_next    = res0_reg;
        res1_next    = res1_reg;
        priority if (proc)
        begin
            res_cnt_next = step_cnt;
            res0_next    = (step_cnt == 2'd1 || step_cnt == 2'd2) ? step_res0 : res0_reg;
            res1_next    = step_res1;
        end
        else if (tx_fire)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
            res0_next    = res1_reg;
        end
        else
        begin
            // nothing moves, buffer holds
            res_cnt_next = res_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_cnt_reg <= 2'd0;
        else
            res_cnt_reg <= res_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    // output channel
    assign tx.valid      = (res_cnt_reg != 2'd0);
    assign tx.out_byte   = res0_reg.out_byte;
    assign tx.run_last   = res0_reg.run_last;
    assign tx.frame_done = res0_reg.frame_done;
    assign tx.frame_bad  = res0_reg.frame_bad;

    // checks on the result buffer and frame tracking
    `FEC_ASSERT_NOW(a_buf_depth, clk, rst_n, 1'b1, res_cnt_reg != 2'd3)
    `FEC_ASSERT_NOW(a_two_not_last, clk, rst_n, res_cnt_reg == 2'd2, !res0_reg.run_last)
    `FEC_ASSERT_NOW(a_done_is_last, clk, rst_n, tx.valid && tx.frame_done, tx.run_last)
    `FEC_ASSERT_NEXT(a_end_clears, clk, rst_n, proc && item_reg.frame_last,
        !state_reg.start_ok && !state_reg.lead_held)

endmodule

@@ test/frame_escape_codec_test.sv @@
// self-checking testbench of frame_escape_codec: directed and random frames in both directions
// depends on fec_pkg, fec_stream_if and the frame_escape_codec rtl
// results are predicted per request and compared in order on the tx channel
module frame_escape_codec_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    fec_in_if  in_ch ();
    fec_out_if out_ch ();

    frame_escape_codec u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (in_ch),
        .tx          (out_ch)
    );

    // frame bytes waiting for the driver and converted bytes waiting for tx
    fec_pkg::item_t   frame_bytes_q [$];
    fec_pkg::result_t expected_bytes [$];

    // predictor copy of the codec state and the direction register
    logic       dir_reg         = fec_pkg::DIR_ENCODE;
    logic       held_lead_valid = 1'b0;
    logic [7:0] held_lead       = 8'h00;
    logic       saw_good_start  = 1'b0;

    // idle percentages of the two channels, set per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int   items_queued    = 0;
    int   items_accepted  = 0;
    int   results_checked = 0;
    int   frames_done     = 0;
    int   mismatch_count  = 0;
    int   cycle_count     = 0;
    logic in_taken;

    // clock, period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
                     expected_bytes.size());
            $display("status: fail");
            $finish;
        end
    end

    // work out the converted bytes of one accepted request
    task automatic convert_byte(input fec_pkg::item_t req);
        logic [7:0]       produced [$];
        logic [7:0]       b;
        fec_pkg::result_t res;
        int               n;
        b = req.in_byte;
        if (req.frame_first)
        begin
            // start flag drops any held lead
            held_lead_valid = 1'b0;
            held_lead       = 8'h00;
            saw_good_start  = (b == fec_pkg::FLAG_START);
            produced.push_back(b);
        end
        else if (req.frame_last)
        begin
            // end flag flushes a held lead in decode mode
            if (dir_reg == fec_pkg::DIR_DECODE && held_lead_valid)
                produced.push_back(held_lead);
            held_lead_valid = 1'b0;
            held_lead       = 8'h00;
            produced.push_back(b);
        end
        else if (dir_reg == fec_pkg::DIR_ENCODE)
        begin
            held_lead_valid = 1'b0;
            held_lead       = 8'h00;
            case (b)
                fec_pkg::FLAG_START:
                begin
                    produced.push_back(fec_pkg::LEAD_A);
                    produced.push_back(fec_pkg::TAIL_ONE);
                end
                fec_pkg::LEAD_A:
                begin
                    produced.push_back(fec_pkg::LEAD_A);
                    produced.push_back(fec_pkg::TAIL_TWO);
                end
                fec_pkg::FLAG_END:
                begin
                    produced.push_back(fec_pkg::LEAD_E);
                    produced.push_back(fec_pkg::TAIL_ONE);
                end
                fec_pkg::LEAD_E:
                begin
                    produced.push_back(fec_pkg::LEAD_E);
                    produced.push_back(fec_pkg::TAIL_TWO);
                end
                default:
                    produced.push_back(b);
            endcase
        end
        else if (held_lead_valid && (b == fec_pkg::TAIL_ONE || b == fec_pkg::TAIL_TWO))
        begin
            // escape pair collapses to one byte
            if (held_lead == fec_pkg::LEAD_A)
                produced.push_back((b == fec_pkg::TAIL_ONE) ? fec_pkg::FLAG_START
                                                            : fec_pkg::LEAD_A);
            else
                produced.push_back((b == fec_pkg::TAIL_ONE) ? fec_pkg::FLAG_END
                                                            : fec_pkg::LEAD_E);
            held_lead_valid = 1'b0;
            held_lead       = 8'h00;
        end
        else
        begin
            // unpaired lead goes out as is, a new lead is held
            if (held_lead_valid)
                produced.push_back(held_lead);
            if (b == fec_pkg::LEAD_A || b == fec_pkg::LEAD_E)
            begin
                held_lead_valid = 1'b1;
                held_lead       = b;
            end
            else
            begin
                held_lead_valid = 1'b0;
                held_lead       = 8'h00;
                produced.push_back(b);
            end
        end

        n = produced.size();
        for (int i = 0; i < n; i++)
        begin
            res.out_byte   = produced[i];
            res.run_last   = (i == n - 1);
            res.frame_done = req.frame_last && (i == n - 1);
            res.frame_bad  = res.frame_done && (!saw_good_start || b != fec_pkg::FLAG_END);
            expected_bytes.push_back(res);
        end
        if (req.frame_last)
            saw_good_start = 1'b0;
    endtask

    // compare one tx result with the oldest expected byte
    task automatic check_result(input fec_pkg::result_t got);
        fec_pkg::result_t want;
        if (expected_bytes.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("cycle %0d: unexpected result byte %02h run_last %0b done %0b bad %0b",
                         cycle_count, got.out_byte, got.run_last, got.frame_done,
                         got.frame_bad);
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.run_last !== want.run_last
                || got.frame_done !== want.frame_done || got.frame_bad !== want.frame_bad)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("cycle %0d: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                             cycle_count, want.out_byte, want.run_last, want.frame_done,
                             want.frame_bad, got.out_byte, got.run_last, got.frame_done,
                             got.frame_bad);
            end
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                convert_byte({in_ch.in_byte, in_ch.frame_first, in_ch.frame_last});
                items_accepted++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                check_result({out_ch.out_byte, out_ch.run_last, out_ch.frame_done,
                              out_ch.frame_bad});
                results_checked++;
                if (out_ch.frame_done)
                    frames_done++;
            end
        end
    end

    // drive requests and tx ready at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        fec_pkg::item_t nxt;
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.in_byte     <= 8'h00;
            in_ch.frame_first <= 1'b0;
            in_ch.frame_last  <= 1'b0;
            out_ch.ready      <= 1'b0;
        end
        else
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (frame_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = frame_bytes_q.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.in_byte     <= nxt.in_byte;
                    in_ch.frame_first <= nxt.frame_first;
                    in_ch.frame_last  <= nxt.frame_last;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic first, input logic last);
        fec_pkg::item_t req;
        req.in_byte     = b;
        req.frame_first = first;
        req.frame_last  = last;
        frame_bytes_q.push_back(req);
        items_queued++;
    endtask

    // interior byte biased toward flags, leads and tails
    function automatic logic [7:0] pick_frame_byte();
        logic [7:0] specials [8];
        specials = '{fec_pkg::FLAG_START, fec_pkg::LEAD_A, fec_pkg::FLAG_END, fec_pkg::LEAD_E,
                     fec_pkg::TAIL_ONE, fec_pkg::TAIL_TWO, 8'h00, 8'hff};
        if ($urandom_range(0, 1) != 0)
            return specials[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    // one random frame: mostly well formed, some single-byte, open or headless
    task automatic queue_random_frame(input logic decode);
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 6)
        begin
            push_byte(($urandom_range(0, 1) != 0) ? fec_pkg::FLAG_START
                                                  : 8'($urandom_range(0, 255)),
                      1'b1, 1'b1);
        end
        else
        begin
            if (kind >= 14)
                push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : fec_pkg::FLAG_START,
                          1'b1, 1'b0);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
            begin
                if (decode && $urandom_range(0, 2) == 0)
                begin
                    push_byte(($urandom_range(0, 1) != 0) ? fec_pkg::LEAD_A : fec_pkg::LEAD_E,
                              1'b0, 1'b0);
                    push_byte(($urandom_range(0, 1) != 0) ? fec_pkg::TAIL_ONE
                                                          : fec_pkg::TAIL_TWO,
                              1'b0, 1'b0);
                end
                else
                begin
                    push_byte(pick_frame_byte(), 1'b0, 1'b0);
                end
            end
            if (kind >= 10)
                push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : fec_pkg::FLAG_END,
                          1'b0, 1'b1);
        end
    endtask

    // sender holds off until every request is in and every result is out
    task automatic wait_drained();
        while (items_accepted != items_queued || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // direction write while the codec is idle
    task automatic write_direction(input logic dir);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        dir_reg = dir;
    endtask

    initial
    begin
        int send_pct_tbl [4];
        int recv_pct_tbl [4];
        int phase_start;
        send_pct_tbl = '{0, 69, 0, 9};
        recv_pct_tbl = '{0, 0, 69, 9};

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // encode: every special interior byte doubles
        write_direction(fec_pkg::DIR_ENCODE);
        push_byte(fec_pkg::FLAG_START, 1'b1, 1'b0);
        push_byte(fec_pkg::FLAG_START, 1'b0, 1'b0);
        push_byte(fec_pkg::LEAD_A, 1'b0, 1'b0);
        push_byte(fec_pkg::FLAG_END, 1'b0, 1'b0);
        push_byte(fec_pkg::LEAD_E, 1'b0, 1'b0);
        push_byte(fec_pkg::FLAG_END, 1'b0, 1'b1);
        // single-byte frame is always bad
        push_byte(fec_pkg::FLAG_START, 1'b1, 1'b1);
        // bad start and bad end flags
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(fec_pkg::FLAG_START, 1'b0, 1'b1);
        // interior byte and end with no start flag
        push_byte(fec_pkg::LEAD_E, 1'b0, 1'b0);
        push_byte(fec_pkg::FLAG_END, 1'b0, 1'b1);
        wait_drained();

        // decode: pairs, lead after lead, lead before a plain byte, lead before end
        write_direction(fec_pkg::DIR_DECODE);
        push_byte(fec_pkg::FLAG_START, 1'b1, 1'b0);
        push_byte(fec_pkg::LEAD_A, 1'b0, 1'b0);
        push_byte(fec_pkg::TAIL_TWO, 1'b0, 1'b0);
        push_byte(fec_pkg::LEAD_E, 1'b0, 1'b0);
        push_byte(fec_pkg::TAIL_ONE, 1'b0, 1'b0);
        push_byte(fec_pkg::LEAD_A, 1'b0, 1'b0);
        push_byte(fec_pkg::LEAD_E, 1'b0, 1'b0);
        push_byte(fec_pkg::TAIL_TWO, 1'b0, 1'b0);
        push_byte(fec_pkg::LEAD_E, 1'b0, 1'b0);
        push_byte(8'hff, 1'b0, 1'b0);
        push_byte(fec_pkg::LEAD_A, 1'b0, 1'b0);
        push_byte(fec_pkg::FLAG_END, 1'b0, 1'b1);
        // a new start flag drops a held lead
        push_byte(fec_pkg::FLAG_START, 1'b1, 1'b0);
        push_byte(fec_pkg::LEAD_E, 1'b0, 1'b0);
        push_byte(fec_pkg::FLAG_START, 1'b1, 1'b0);
        push_byte(fec_pkg::LEAD_A, 1'b0, 1'b0);
        wait_drained();

        // lead still held when the direction turns to encode is dropped
        write_direction(fec_pkg::DIR_ENCODE);
        push_byte(8'h33, 1'b0, 1'b0);
        push_byte(fec_pkg::FLAG_END, 1'b0, 1'b1);
        wait_drained();

        // random phases over all idle profiles in both directions
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_direction(phase[0] ? fec_pkg::DIR_DECODE : fec_pkg::DIR_ENCODE);
            send_idle_pct  = send_pct_tbl[phase >> 1];
            recv_stall_pct = recv_pct_tbl[phase >> 1];
            phase_start    = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS)
                queue_random_frame(phase[0]);
            wait_drained();
        end

        repeat (10) @(negedge clk);

        $display("covered %0d requests, %0d converted bytes and %0d frame ends", items_accepted,
                 results_checked, frames_done);
        $display("both directions under four idle profiles, %0d mismatches", mismatch_count);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
